// ===== src/query_language_lexer_defines.svh =====
// Assertion macros for the lexer's checker file.
// Depends on nothing; the including module must provide clk_i and rst_ni.
`ifndef QUERY_LANGUAGE_LEXER_DEFINES_SVH
`define QUERY_LANGUAGE_LEXER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define QLL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define QLL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/qll_pkg.sv =====
// Types, codes, word tables and character helpers for the query lexer.
// Used by qll_step and query_language_lexer; depends on nothing.
package qll_pkg;

  localparam int unsigned NUM_WORDS = 13;
  localparam int unsigned MAX_RES   = 4;
  localparam int unsigned RES_CNT_W = 3;

  localparam logic [NUM_WORDS-1:0] ALL_WORDS = '1;

  // One-hot lexer mode.
  typedef enum logic [7:0] {
    MODE_IDLE   = 8'b0000_0001,
    MODE_IDENT  = 8'b0000_0010,
    MODE_NUMBER = 8'b0000_0100,
    MODE_VAR    = 8'b0000_1000,
    MODE_DIR    = 8'b0001_0000,
    MODE_STRING = 8'b0010_0000,
    MODE_ESCAPE = 8'b0100_0000,
    MODE_ERROR  = 8'b1000_0000
  } mode_e;

  // Result kinds.
  localparam logic [1:0] KIND_VALUE = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // Token types.
  localparam logic [3:0] TYPE_BRACE_OPEN  = 4'd0;
  localparam logic [3:0] TYPE_BRACE_CLOSE = 4'd1;
  localparam logic [3:0] TYPE_PAREN_OPEN  = 4'd2;
  localparam logic [3:0] TYPE_PAREN_CLOSE = 4'd3;
  localparam logic [3:0] TYPE_COLON       = 4'd4;
  localparam logic [3:0] TYPE_COMMA       = 4'd5;
  localparam logic [3:0] TYPE_BANG        = 4'd6;
  localparam logic [3:0] TYPE_VAR         = 4'd7;
  localparam logic [3:0] TYPE_DIR         = 4'd8;
  localparam logic [3:0] TYPE_STRING      = 4'd9;
  localparam logic [3:0] TYPE_KEYWORD     = 4'd10;
  localparam logic [3:0] TYPE_OUTTYPE     = 4'd11;
  localparam logic [3:0] TYPE_IDENT       = 4'd12;
  localparam logic [3:0] TYPE_NUMBER      = 4'd13;
  localparam logic [3:0] TYPE_END         = 4'd14;

  // Error codes.
  localparam logic [2:0] ERR_NONE        = 3'd0;
  localparam logic [2:0] ERR_UNKNOWN     = 3'd1;
  localparam logic [2:0] ERR_OPEN_ESCAPE = 3'd2;
  localparam logic [2:0] ERR_BAD_ESCAPE  = 3'd3;
  localparam logic [2:0] ERR_OPEN_STRING = 3'd4;

  // Index of the first output type among the fixed words.
  localparam logic [3:0] FIRST_OUTTYPE = 4'd8;

  // Characters with a meaning of their own.
  localparam logic [7:0] CH_BRACE_OPEN  = 8'h7B;
  localparam logic [7:0] CH_BRACE_CLOSE = 8'h7D;
  localparam logic [7:0] CH_PAREN_OPEN  = 8'h28;
  localparam logic [7:0] CH_PAREN_CLOSE = 8'h29;
  localparam logic [7:0] CH_COLON       = 8'h3A;
  localparam logic [7:0] CH_COMMA       = 8'h2C;
  localparam logic [7:0] CH_BANG        = 8'h21;
  localparam logic [7:0] CH_DOLLAR      = 8'h24;
  localparam logic [7:0] CH_AT          = 8'h40;
  localparam logic [7:0] CH_QUOTE       = 8'h22;
  localparam logic [7:0] CH_BACKSLASH   = 8'h5C;
  localparam logic [7:0] CH_MINUS       = 8'h2D;
  localparam logic [7:0] CH_UNDERSCORE  = 8'h5F;
  localparam logic [7:0] CH_SPACE       = 8'h20;

  // Fixed words, right-aligned: the first character sits in the highest used byte.
  localparam logic [127:0] WORD_TEXT [NUM_WORDS] = '{
    128'("query"), 128'("mutation"), 128'("subscription"), 128'("fragment"),
    128'("on"), 128'("true"), 128'("false"), 128'("null"),
    128'("String"), 128'("Int"), 128'("Float"), 128'("Boolean"), 128'("ID")
  };
  localparam logic [3:0] WORD_LEN [NUM_WORDS] = '{
    4'd5, 4'd8, 4'd12, 4'd8, 4'd2, 4'd4, 4'd5, 4'd4, 4'd6, 4'd3, 4'd5, 4'd7, 4'd2
  };

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] ttype;
    logic [7:0] value;
    logic [3:0] windex;
    logic [2:0] err;
    logic       done;
  } res_t;

  typedef struct packed {
    mode_e                mode;
    logic [NUM_WORDS-1:0] mask;
    logic [3:0]           len;
  } lex_state_t;

  localparam lex_state_t STATE_RESET = '{mode: MODE_IDLE, mask: ALL_WORDS, len: 4'd0};

  function automatic logic is_letter(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_word(logic [7:0] c);
    return is_letter(c) || is_digit(c) || c == CH_UNDERSCORE;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic res_t make_res(logic [1:0] kind, logic [3:0] ttype, logic [7:0] value,
                                    logic [3:0] windex, logic [2:0] err, logic done);
    res_t r;
    r.kind   = kind;
    r.ttype  = ttype;
    r.value  = value;
    r.windex = windex;
    r.err    = err;
    r.done   = done;
    return r;
  endfunction

  // Keep word w only while the name so far is still a prefix of it.
  function automatic logic [NUM_WORDS-1:0] word_advance(logic [NUM_WORDS-1:0] mask,
                                                        logic [3:0] len, logic [7:0] c);
    logic [NUM_WORDS-1:0] m;
    logic [3:0]           pos;
    m = mask;
    for (int w = 0; w < NUM_WORDS; w++) begin
      pos = WORD_LEN[w] - 4'd1 - len;
      if (!(len < WORD_LEN[w] && WORD_TEXT[w][{pos, 3'b000} +: 8] == c)) begin
        m[w] = 1'b0;
      end
    end
    return m;
  endfunction

  function automatic logic [3:0] len_step(logic [3:0] len);
    return (len == 4'hF) ? len : len + 4'd1;
  endfunction

  function automatic logic is_open_word(mode_e m);
    return m == MODE_IDENT || m == MODE_NUMBER || m == MODE_VAR || m == MODE_DIR;
  endfunction

  // Token end for an open identifier, number, variable or directive.
  function automatic res_t close_token(lex_state_t s);
    res_t r;
    r = make_res(KIND_END, TYPE_IDENT, 8'h00, 4'd0, ERR_NONE, 1'b0);
    case (s.mode)
      MODE_IDENT: begin
        // Walk from the top so the lowest matching word wins.
        for (int w = NUM_WORDS - 1; w >= 0; w--) begin
          if (s.mask[w] && WORD_LEN[w] == s.len) begin
            r.windex = 4'(w);
            r.ttype  = (4'(w) < FIRST_OUTTYPE) ? TYPE_KEYWORD : TYPE_OUTTYPE;
          end
        end
      end
      MODE_NUMBER: r.ttype = TYPE_NUMBER;
      MODE_VAR:    r.ttype = TYPE_VAR;
      MODE_DIR:    r.ttype = TYPE_DIR;
      default:     r.ttype = TYPE_IDENT;
    endcase
    return r;
  endfunction

endpackage

// ===== src/qll_step.sv =====
// Combinational lexing of one character: next lexer state and up to four results.
// Depends on qll_pkg.
module qll_step
  import qll_pkg::*;
(
  input  lex_state_t                 state_i,
  input  logic [7:0]                 char_i,
  input  logic                       last_i,
  output lex_state_t                 state_o,
  output res_t [MAX_RES-1:0]         res_o,
  output logic [RES_CNT_W-1:0]       count_o
);

  always_comb begin
    lex_state_t          st;
    res_t [MAX_RES-1:0]  res;
    logic [RES_CNT_W-1:0] n;
    logic                do_close;
    logic                do_idle;

    st       = state_i;
    res      = '0;
    n        = '0;
    do_close = 1'b0;
    do_idle  = 1'b0;

    case (state_i.mode)
      MODE_IDLE: do_idle = 1'b1;
      MODE_IDENT: begin
        if (is_word(char_i)) begin
          st.mask = word_advance(state_i.mask, state_i.len, char_i);
          st.len  = len_step(state_i.len);
          res[n[1:0]] = make_res(KIND_VALUE, TYPE_IDENT, char_i, 4'd0, ERR_NONE, 1'b0);
          n = n + RES_CNT_W'(1);
        end else begin
          do_close = 1'b1;
          do_idle  = 1'b1;
        end
      end
      MODE_NUMBER: begin
        if (is_digit(char_i)) begin
          res[n[1:0]] = make_res(KIND_VALUE, TYPE_NUMBER, char_i, 4'd0, ERR_NONE, 1'b0);
          n = n + RES_CNT_W'(1);
        end else begin
          do_close = 1'b1;
          do_idle  = 1'b1;
        end
      end
      MODE_VAR, MODE_DIR: begin
        if (is_word(char_i)) begin
          res[n[1:0]] = make_res(KIND_VALUE,
                                 (state_i.mode == MODE_VAR) ? TYPE_VAR : TYPE_DIR,
                                 char_i, 4'd0, ERR_NONE, 1'b0);
          n = n + RES_CNT_W'(1);
        end else begin
          do_close = 1'b1;
          do_idle  = 1'b1;
        end
      end
      MODE_STRING: begin
        if (char_i == CH_BACKSLASH) begin
          st.mode = MODE_ESCAPE;
        end else if (char_i == CH_QUOTE) begin
          st.mode = MODE_IDLE;
          res[n[1:0]] = make_res(KIND_END, TYPE_STRING, 8'h00, 4'd0, ERR_NONE, 1'b0);
          n = n + RES_CNT_W'(1);
        end else begin
          res[n[1:0]] = make_res(KIND_VALUE, TYPE_STRING, char_i, 4'd0, ERR_NONE, 1'b0);
          n = n + RES_CNT_W'(1);
        end
      end
      MODE_ESCAPE: begin
        st.mode = MODE_STRING;
        case (char_i)
          8'h6E: res[n[1:0]] = make_res(KIND_VALUE, TYPE_STRING, 8'h0A, 4'd0,
                                        ERR_NONE, 1'b0);
          8'h74: res[n[1:0]] = make_res(KIND_VALUE, TYPE_STRING, 8'h09, 4'd0,
                                        ERR_NONE, 1'b0);
          CH_BACKSLASH: res[n[1:0]] = make_res(KIND_VALUE, TYPE_STRING, CH_BACKSLASH, 4'd0,
                                               ERR_NONE, 1'b0);
          CH_QUOTE: res[n[1:0]] = make_res(KIND_VALUE, TYPE_STRING, CH_QUOTE, 4'd0,
                                           ERR_NONE, 1'b0);
          8'h72: res[n[1:0]] = make_res(KIND_VALUE, TYPE_STRING, 8'h0D, 4'd0,
                                        ERR_NONE, 1'b0);
          8'h62: res[n[1:0]] = make_res(KIND_VALUE, TYPE_STRING, 8'h08, 4'd0,
                                        ERR_NONE, 1'b0);
          8'h66: res[n[1:0]] = make_res(KIND_VALUE, TYPE_STRING, 8'h0C, 4'd0,
                                        ERR_NONE, 1'b0);
          default: begin
            st.mode = MODE_ERROR;
            res[n[1:0]] = make_res(KIND_ERROR, TYPE_BRACE_OPEN, char_i, 4'd0,
                                   ERR_BAD_ESCAPE, 1'b0);
          end
        endcase
        n = n + RES_CNT_W'(1);
      end
      default: ;
    endcase

    // A byte that ends a word token first closes it, then is lexed from idle.
    if (do_close) begin
      res[n[1:0]] = close_token(state_i);
      n = n + RES_CNT_W'(1);
      st.mode = MODE_IDLE;
    end

    if (do_idle) begin
      case (char_i)
        CH_BRACE_OPEN, CH_BRACE_CLOSE, CH_PAREN_OPEN, CH_PAREN_CLOSE,
        CH_COLON, CH_COMMA, CH_BANG: begin
          res[n[1:0]] = make_res(KIND_END, TYPE_BRACE_OPEN, char_i, 4'd0, ERR_NONE, 1'b0);
          case (char_i)
            CH_BRACE_CLOSE: res[n[1:0]].ttype = TYPE_BRACE_CLOSE;
            CH_PAREN_OPEN:  res[n[1:0]].ttype = TYPE_PAREN_OPEN;
            CH_PAREN_CLOSE: res[n[1:0]].ttype = TYPE_PAREN_CLOSE;
            CH_COLON:       res[n[1:0]].ttype = TYPE_COLON;
            CH_COMMA:       res[n[1:0]].ttype = TYPE_COMMA;
            CH_BANG:        res[n[1:0]].ttype = TYPE_BANG;
            default:        res[n[1:0]].ttype = TYPE_BRACE_OPEN;
          endcase
          n = n + RES_CNT_W'(1);
        end
        CH_DOLLAR: st.mode = MODE_VAR;
        CH_AT:     st.mode = MODE_DIR;
        CH_QUOTE:  st.mode = MODE_STRING;
        default: begin
          if (is_space(char_i)) begin
            st.mode = MODE_IDLE;
          end else if (is_letter(char_i)) begin
            st.mode = MODE_IDENT;
            st.mask = word_advance(ALL_WORDS, 4'd0, char_i);
            st.len  = 4'd1;
            res[n[1:0]] = make_res(KIND_VALUE, TYPE_IDENT, char_i, 4'd0, ERR_NONE, 1'b0);
            n = n + RES_CNT_W'(1);
          end else if (is_digit(char_i) || char_i == CH_MINUS) begin
            st.mode = MODE_NUMBER;
            res[n[1:0]] = make_res(KIND_VALUE, TYPE_NUMBER, char_i, 4'd0, ERR_NONE, 1'b0);
            n = n + RES_CNT_W'(1);
          end else begin
            st.mode = MODE_ERROR;
            res[n[1:0]] = make_res(KIND_ERROR, TYPE_BRACE_OPEN, char_i, 4'd0,
                                   ERR_UNKNOWN, 1'b0);
            n = n + RES_CNT_W'(1);
          end
        end
      endcase
    end

    // End of text: flush an open word or flag open string/escape, then end token.
    if (last_i) begin
      if (st.mode == MODE_STRING) begin
        res[n[1:0]] = make_res(KIND_ERROR, TYPE_BRACE_OPEN, 8'h00, 4'd0,
                               ERR_OPEN_STRING, 1'b0);
        n = n + RES_CNT_W'(1);
      end else if (st.mode == MODE_ESCAPE) begin
        res[n[1:0]] = make_res(KIND_ERROR, TYPE_BRACE_OPEN, 8'h00, 4'd0,
                               ERR_OPEN_ESCAPE, 1'b0);
        n = n + RES_CNT_W'(1);
      end else if (is_open_word(st.mode)) begin
        res[n[1:0]] = close_token(st);
        n = n + RES_CNT_W'(1);
      end
      res[n[1:0]] = make_res(KIND_END, TYPE_END, 8'h00, 4'd0, ERR_NONE, 1'b1);
      n = n + RES_CNT_W'(1);
      st = STATE_RESET;
    end

    state_o = st;
    res_o   = res;
    count_o = n;
  end

endmodule

// ===== src/query_language_lexer.sv =====
// Top level of the query lexer: input handshake, lexer state, result batch
// and output register. Depends on qll_pkg and qll_step.
//
//   Channel  | Direction | tdata                 | tuser       | tlast
//   ---------+-----------+-----------------------+-------------+------------
//   s_axis   | in        | char_byte             | -           | end_of_text
//   m_axis   | out       | type/value/index/err  | result_kind | stream_done
//
// Each accepted character is lexed in the cycle it is accepted; its zero to
// four results land together in a four-entry batch register. The output port
// sets the rate: unless m_axis stalls, the batch drains one result per cycle
// into the output register and an item with one result or none flows at one
// item per cycle; an item with more results delays the next. Reset returns
// the lexer to idle with an empty batch and no valid output. A stall on m_axis
// holds the output item and backs up into s_axis once the batch cannot drain.
module query_language_lexer
  import qll_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_byte
  input  logic        s_axis_tlast,   // end_of_text
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [3:0] token_type, [11:4] value_byte,
                                      // [15:12] word_index, [18:16] error_code,
                                      // [23:19] zero
  output logic [1:0]  m_axis_tuser,   // [1:0] result_kind
  output logic        m_axis_tlast    // stream_done
);

  // Lexer state, updated once per accepted item.
  lex_state_t st_q, st_d;

  // Results of the last accepted item that still wait for the output register.
  res_t [MAX_RES-1:0]      bat_q;
  res_t [MAX_RES-1:0]      step_res;
  logic [RES_CNT_W-1:0]    bat_cnt_q, bat_cnt_d;
  logic [RES_CNT_W-1:0]    step_cnt;
  logic [1:0]              bat_head_q, bat_head_d;

  // Output register.
  res_t out_q;
  logic out_vld_q, out_vld_d;

  logic in_fire;
  logic load_out;

  qll_step u_step (
    .state_i (st_q),
    .char_i  (s_axis_tdata),
    .last_i  (s_axis_tlast),
    .state_o (st_d),
    .res_o   (step_res),
    .count_o (step_cnt)
  );

  // The output register takes the head of the batch whenever it is empty or
  // its item is being taken downstream.
  assign load_out = (bat_cnt_q != '0) && (!out_vld_q || m_axis_tready);

  // A new item may enter once the batch is empty or about to become empty.
  assign s_axis_tready = (bat_cnt_q == '0) ||
                         (bat_cnt_q == RES_CNT_W'(1) && load_out);
  assign in_fire = s_axis_tvalid && s_axis_tready;

  always_comb begin
    bat_cnt_d  = bat_cnt_q;
    bat_head_d = bat_head_q;
    if (in_fire) begin
      bat_cnt_d  = step_cnt;
      bat_head_d = 2'd0;
    end else if (load_out) begin
      bat_cnt_d  = bat_cnt_q - RES_CNT_W'(1);
      bat_head_d = bat_head_q + 2'd1;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (load_out) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= STATE_RESET;
      bat_cnt_q  <= '0;
      bat_head_q <= 2'd0;
      out_vld_q  <= 1'b0;
    end else begin
      if (in_fire) begin
        st_q <= st_d;
      end
      bat_cnt_q  <= bat_cnt_d;
      bat_head_q <= bat_head_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      bat_q <= step_res;
    end
    if (load_out) begin
      out_q <= bat_q[bat_head_q];
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {5'b0, out_q.err, out_q.windex, out_q.value, out_q.ttype};
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_q.done;

endmodule

// ===== src/qll_checker.sv =====
// Port-level checks on the lexer's result stream, bound to the top level.
// Depends on query_language_lexer_defines.svh and qll_pkg.
`include "query_language_lexer_defines.svh"

module qll_checker
  import qll_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // A stalled item holds.
  `QLL_ASSERT_NEXT(a_stall_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "result changed while stalled")

  // The end-of-input item is a plain token end of the end type.
  `QLL_ASSERT_NOW(a_end_shape, m_axis_tvalid && m_axis_tlast, m_axis_tuser == KIND_END && m_axis_tdata[3:0] == TYPE_END && m_axis_tdata[18:16] == ERR_NONE, "malformed end-of-input item")

  // Errors carry a nonzero code and type zero; other items carry no code.
  `QLL_ASSERT_NOW(a_error_shape, m_axis_tvalid, (m_axis_tuser == KIND_ERROR) == (m_axis_tdata[18:16] != ERR_NONE) && (m_axis_tuser != KIND_ERROR || m_axis_tdata[3:0] == TYPE_BRACE_OPEN), "error code does not match result kind")

  // Keywords index the first eight words, output types the last five.
  `QLL_ASSERT_NOW(a_word_index, m_axis_tvalid && m_axis_tuser == KIND_END && (m_axis_tdata[3:0] == TYPE_KEYWORD || m_axis_tdata[3:0] == TYPE_OUTTYPE), (m_axis_tdata[3:0] == TYPE_KEYWORD) == (m_axis_tdata[15:12] < FIRST_OUTTYPE) && m_axis_tdata[15:12] <= 4'(NUM_WORDS - 1), "word index out of range for class")

endmodule

bind query_language_lexer qll_checker u_qll_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// ===== sim/tb_query_language_lexer.sv =====
// Self-checking testbench for query_language_lexer: directed texts, a long
// output stall and random queries, checked against a lexer model kept here.
// Depends on qll_pkg for the result struct, lexer modes and token codes.
module tb_query_language_lexer;
  import qll_pkg::*;

  localparam int          WATCHDOG_LIMIT = 1000;
  localparam int          HOLD_CYCLES    = 80;
  localparam int          TAIL_CYCLES    = 16;
  localparam logic [3:0]  TYPE_NONE      = 4'd0;  // errors carry token type zero

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  query_language_lexer dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Lexer model state and the results it has predicted but not yet seen.
  mode_e                lex_st;
  logic [NUM_WORDS-1:0] lex_mask;
  logic [3:0]           lex_len;
  res_t                 predicted_lexemes [$];

  string word_list [NUM_WORDS] = '{
    "query", "mutation", "subscription", "fragment", "on", "true", "false", "null",
    "String", "Int", "Float", "Boolean", "ID"
  };

  logic [7:0] query_buf [$];
  int         live_items;
  int         mismatch_count;
  int         idle_cycles;
  bit         tx_idling;
  bit         rx_idling;
  bit         rx_hold_req;

  function automatic bit ch_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit ch_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit ch_name(logic [7:0] c);
    return ch_alpha(c) || ch_digit(c) || c == CH_UNDERSCORE;
  endfunction

  function automatic bit ch_blank(logic [7:0] c);
    return c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  // Adds one character to the end of the text being built.
  function automatic void buf_put(logic [7:0] c);
    query_buf = {query_buf, c};
  endfunction

  function automatic void push_lexeme(logic [1:0] kind, logic [3:0] ttype, logic [7:0] value,
                                      logic [3:0] windex, logic [2:0] err, logic done);
    res_t r;
    r.kind   = kind;
    r.ttype  = ttype;
    r.value  = value;
    r.windex = windex;
    r.err    = err;
    r.done   = done;
    predicted_lexemes = {predicted_lexemes, r};
  endfunction

  function automatic void reset_lexer();
    lex_st   = MODE_IDLE;
    lex_mask = '1;
    lex_len  = 4'd0;
  endfunction

  // Drop every fixed word that the name so far no longer prefixes.
  function automatic void narrow_words(logic [7:0] c);
    for (int w = 0; w < NUM_WORDS; w++) begin
      if (!(int'(lex_len) < word_list[w].len() && 8'(word_list[w][lex_len]) == c)) begin
        lex_mask[w] = 1'b0;
      end
    end
    lex_len = (lex_len == 4'hF) ? 4'hF : lex_len + 4'd1;
  endfunction

  // Ends an open name, number, variable or directive; lowest matching word wins.
  function automatic void end_open_token();
    bit found;
    found = 1'b0;
    case (lex_st)
      MODE_IDENT: begin
        for (int w = 0; w < NUM_WORDS; w++) begin
          if (!found && lex_mask[w] && int'(lex_len) == word_list[w].len()) begin
            push_lexeme(KIND_END, (w < int'(FIRST_OUTTYPE)) ? TYPE_KEYWORD : TYPE_OUTTYPE,
                        8'h00, 4'(w), ERR_NONE, 1'b0);
            found = 1'b1;
          end
        end
        if (!found) push_lexeme(KIND_END, TYPE_IDENT, 8'h00, 4'd0, ERR_NONE, 1'b0);
      end
      MODE_NUMBER: push_lexeme(KIND_END, TYPE_NUMBER, 8'h00, 4'd0, ERR_NONE, 1'b0);
      MODE_VAR:    push_lexeme(KIND_END, TYPE_VAR, 8'h00, 4'd0, ERR_NONE, 1'b0);
      MODE_DIR:    push_lexeme(KIND_END, TYPE_DIR, 8'h00, 4'd0, ERR_NONE, 1'b0);
      default: ;
    endcase
    lex_st = MODE_IDLE;
  endfunction

  // A character seen with no token open.
  function automatic void begin_token(logic [7:0] c);
    case (c)
      CH_BRACE_OPEN:  push_lexeme(KIND_END, TYPE_BRACE_OPEN, c, 4'd0, ERR_NONE, 1'b0);
      CH_BRACE_CLOSE: push_lexeme(KIND_END, TYPE_BRACE_CLOSE, c, 4'd0, ERR_NONE, 1'b0);
      CH_PAREN_OPEN:  push_lexeme(KIND_END, TYPE_PAREN_OPEN, c, 4'd0, ERR_NONE, 1'b0);
      CH_PAREN_CLOSE: push_lexeme(KIND_END, TYPE_PAREN_CLOSE, c, 4'd0, ERR_NONE, 1'b0);
      CH_COLON:       push_lexeme(KIND_END, TYPE_COLON, c, 4'd0, ERR_NONE, 1'b0);
      CH_COMMA:       push_lexeme(KIND_END, TYPE_COMMA, c, 4'd0, ERR_NONE, 1'b0);
      CH_BANG:        push_lexeme(KIND_END, TYPE_BANG, c, 4'd0, ERR_NONE, 1'b0);
      CH_DOLLAR:      lex_st = MODE_VAR;
      CH_AT:          lex_st = MODE_DIR;
      CH_QUOTE:       lex_st = MODE_STRING;
      default: begin
        if (ch_blank(c)) begin
        end else if (ch_alpha(c)) begin
          lex_st   = MODE_IDENT;
          lex_mask = '1;
          lex_len  = 4'd0;
          narrow_words(c);
          push_lexeme(KIND_VALUE, TYPE_IDENT, c, 4'd0, ERR_NONE, 1'b0);
        end else if (ch_digit(c) || c == CH_MINUS) begin
          lex_st = MODE_NUMBER;
          push_lexeme(KIND_VALUE, TYPE_NUMBER, c, 4'd0, ERR_NONE, 1'b0);
        end else begin
          lex_st = MODE_ERROR;
          push_lexeme(KIND_ERROR, TYPE_NONE, c, 4'd0, ERR_UNKNOWN, 1'b0);
        end
      end
    endcase
  endfunction

  // Predicts the results of one accepted character.
  function automatic void lex_char(logic [7:0] c, logic last);
    logic [7:0] decoded;
    bit         known;
    case (lex_st)
      MODE_IDLE: begin_token(c);
      MODE_IDENT: begin
        if (ch_name(c)) begin
          narrow_words(c);
          push_lexeme(KIND_VALUE, TYPE_IDENT, c, 4'd0, ERR_NONE, 1'b0);
        end else begin
          end_open_token();
          begin_token(c);
        end
      end
      MODE_NUMBER: begin
        if (ch_digit(c)) begin
          push_lexeme(KIND_VALUE, TYPE_NUMBER, c, 4'd0, ERR_NONE, 1'b0);
        end else begin
          end_open_token();
          begin_token(c);
        end
      end
      MODE_VAR, MODE_DIR: begin
        if (ch_name(c)) begin
          push_lexeme(KIND_VALUE, (lex_st == MODE_VAR) ? TYPE_VAR : TYPE_DIR, c, 4'd0,
                      ERR_NONE, 1'b0);
        end else begin
          end_open_token();
          begin_token(c);
        end
      end
      MODE_STRING: begin
        if (c == CH_BACKSLASH) begin
          lex_st = MODE_ESCAPE;
        end else if (c == CH_QUOTE) begin
          lex_st = MODE_IDLE;
          push_lexeme(KIND_END, TYPE_STRING, 8'h00, 4'd0, ERR_NONE, 1'b0);
        end else begin
          push_lexeme(KIND_VALUE, TYPE_STRING, c, 4'd0, ERR_NONE, 1'b0);
        end
      end
      MODE_ESCAPE: begin
        known = 1'b1;
        case (c)
          "n":          decoded = 8'h0A;  // line feed
          "t":          decoded = 8'h09;  // tab
          CH_BACKSLASH: decoded = CH_BACKSLASH;
          CH_QUOTE:     decoded = CH_QUOTE;
          "r":          decoded = 8'h0D;  // carriage return
          "b":          decoded = 8'h08;  // backspace
          "f":          decoded = 8'h0C;  // form feed
          default: begin
            decoded = 8'h00;
            known   = 1'b0;
          end
        endcase
        if (known) begin
          lex_st = MODE_STRING;
          push_lexeme(KIND_VALUE, TYPE_STRING, decoded, 4'd0, ERR_NONE, 1'b0);
        end else begin
          lex_st = MODE_ERROR;
          push_lexeme(KIND_ERROR, TYPE_NONE, c, 4'd0, ERR_BAD_ESCAPE, 1'b0);
        end
      end
      default: ;  // the error mode swallows everything up to the end of the text
    endcase

    if (last) begin
      if (lex_st == MODE_STRING) begin
        push_lexeme(KIND_ERROR, TYPE_NONE, 8'h00, 4'd0, ERR_OPEN_STRING, 1'b0);
      end else if (lex_st == MODE_ESCAPE) begin
        push_lexeme(KIND_ERROR, TYPE_NONE, 8'h00, 4'd0, ERR_OPEN_ESCAPE, 1'b0);
      end else if (lex_st != MODE_ERROR) begin
        end_open_token();
      end
      push_lexeme(KIND_END, TYPE_END, 8'h00, 4'd0, ERR_NONE, 1'b1);
      reset_lexer();
    end
  endfunction

  // Offers one character, waits for it to be taken and may then pause the stream.
  task automatic send_item(input logic [7:0] c, input logic last);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    live_items++;
    lex_char(c, last);
    if (tx_idling && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
  endtask

  // Sends the buffered text, marking its final character, and empties the buffer.
  task automatic send_query();
    for (int i = 0; i < query_buf.size(); i++) begin
      send_item(query_buf[i], i == query_buf.size() - 1);
    end
    query_buf.delete();
  endtask

  function automatic void append_text(string s);
    for (int i = 0; i < s.len(); i++) buf_put(8'(s[i]));
  endfunction

  // Lets the stream go quiet until every predicted result has come out.
  task automatic wait_for_results();
    if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
    while (predicted_lexemes.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [7:0] rand_letter();
    int r;
    r = $urandom_range(0, 51);
    return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
  endfunction

  function automatic logic [7:0] rand_name_char();
    int r;
    r = $urandom_range(0, 62);
    if (r < 52) return rand_letter();
    if (r < 62) return 8'("0" + r - 52);
    return CH_UNDERSCORE;
  endfunction

  // Appends one random token, mostly well formed, then an optional separator.
  function automatic void add_random_token();
    int         pick;
    int         n;
    int         w;
    logic [7:0] c;
    logic [7:0] punct [7] = '{CH_BRACE_OPEN, CH_BRACE_CLOSE, CH_PAREN_OPEN, CH_PAREN_CLOSE,
                              CH_COLON, CH_COMMA, CH_BANG};
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      w = $urandom_range(0, NUM_WORDS - 1);
      case ($urandom_range(0, 5))
        0:       append_text(word_list[w].substr(0, word_list[w].len() - 2));
        1: begin
          append_text(word_list[w]);
          buf_put(rand_name_char());
        end
        default: append_text(word_list[w]);
      endcase
    end else if (pick < 37) begin
      // Plain names; some run past the length counter's limit.
      n = ($urandom_range(0, 5) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 6);
      buf_put(rand_letter());
      repeat (n - 1) buf_put(rand_name_char());
    end else if (pick < 50) begin
      if ($urandom_range(0, 2) == 0) begin
        buf_put(CH_MINUS);
        n = $urandom_range(0, 3);
      end else begin
        n = $urandom_range(1, 4);
      end
      repeat (n) buf_put(8'("0" + $urandom_range(0, 9)));
    end else if (pick < 60) begin
      buf_put($urandom_range(0, 1) ? CH_DOLLAR : CH_AT);
      repeat ($urandom_range(0, 5)) buf_put(rand_name_char());
    end else if (pick < 72) begin
      buf_put(CH_QUOTE);
      repeat ($urandom_range(0, 6)) begin
        if ($urandom_range(0, 3) == 0) begin
          buf_put(CH_BACKSLASH);
          case ($urandom_range(0, 7))
            0: buf_put("n");
            1: buf_put("t");
            2: buf_put(CH_BACKSLASH);
            3: buf_put(CH_QUOTE);
            4: buf_put("r");
            5: buf_put("b");
            6: buf_put("f");
            default: buf_put(8'($urandom_range(0, 255)));
          endcase
        end else begin
          c = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(8'h20, 8'h7E));
          if (c == CH_QUOTE || c == CH_BACKSLASH) c = "s";
          buf_put(c);
        end
      end
      // Now and then the string is left open.
      if ($urandom_range(0, 9) != 0) buf_put(CH_QUOTE);
    end else if (pick < 91) begin
      buf_put(punct[$urandom_range(0, 6)]);
    end else begin
      buf_put(8'($urandom_range(0, 255)));
    end

    case ($urandom_range(0, 3))
      0: ;
      1: buf_put(8'($urandom_range(8'h09, 8'h0D)));
      default: buf_put(CH_SPACE);
    endcase
  endfunction

  // Punctuation, empty variable and directive, lone minus, escapes and errors.
  task automatic test_directed();
    append_text("{}():,!");
    send_query();
    append_text("$,@-on");
    send_query();
    append_text("\"\\n\\q");
    send_query();
    buf_put(8'h00);
    buf_put(8'hFF);
    send_query();
    append_text("\"\\");
    send_query();
    append_text("\"");
    send_query();
    wait_for_results();
  endtask

  // The output is held off while a long, result-heavy text keeps coming.
  task automatic test_output_stall();
    rx_hold_req = 1'b1;
    append_text("subscriptionqueryID_x1 query($id:ID!){f@skip -12 \"a\\tb\"}");
    send_query();
    wait_for_results();
  endtask

  task automatic test_random_queries(input int target);
    int first;
    first = live_items;
    while (live_items - first < target) begin
      repeat ($urandom_range(2, 10)) add_random_token();
      send_query();
    end
    wait_for_results();
  endtask

  // Output side: random stalls, plus one long hold-off when asked for.
  initial begin
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        rx_hold_req = 1'b0;
        m_axis_tready <= 1'b1;
      end else if (rx_idling && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic void note_mismatch(string what, int unsigned want, int unsigned got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("mismatch at %0t: %s expected %0d, got %0d", $realtime, what, want, got);
    end
  endfunction

  // Each result leaving the block is held against the oldest prediction.
  always @(posedge clk_i) begin : result_check
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (predicted_lexemes.size() == 0) begin
        note_mismatch("unexpected result, tdata", 32'd0, 32'(m_axis_tdata));
      end else begin
        want = predicted_lexemes.pop_front();
        if (m_axis_tuser != want.kind)
          note_mismatch("result_kind", 32'(want.kind), 32'(m_axis_tuser));
        if (m_axis_tdata[3:0] != want.ttype)
          note_mismatch("token_type", 32'(want.ttype), 32'(m_axis_tdata[3:0]));
        if (m_axis_tdata[11:4] != want.value)
          note_mismatch("value_byte", 32'(want.value), 32'(m_axis_tdata[11:4]));
        if (m_axis_tdata[15:12] != want.windex)
          note_mismatch("word_index", 32'(want.windex), 32'(m_axis_tdata[15:12]));
        if (m_axis_tdata[18:16] != want.err)
          note_mismatch("error_code", 32'(want.err), 32'(m_axis_tdata[18:16]));
        if (m_axis_tdata[23:19] != 5'd0)
          note_mismatch("tdata padding", 32'd0, 32'(m_axis_tdata[23:19]));
        if (m_axis_tlast != want.done)
          note_mismatch("stream_done", 32'(want.done), 32'(m_axis_tlast));
      end
    end
  end

  // Ends a hung run: too long a stretch with no handshake on either side.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    rst_ni         <= 1'b0;
    s_axis_tvalid  <= 1'b0;
    s_axis_tdata   <= 8'h00;
    s_axis_tlast   <= 1'b0;
    live_items     = 0;
    mismatch_count = 0;
    idle_cycles    = 0;
    tx_idling      = 1'b1;
    rx_idling      = 1'b1;
    rx_hold_req    = 1'b0;
    reset_lexer();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_output_stall();
    test_random_queries(140);
    // Last stretch at full rate on both sides.
    tx_idling = 1'b0;
    rx_idling = 1'b0;
    test_random_queries(50);

    if (mismatch_count == 0 && predicted_lexemes.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
